@@ sv/rv32sx_pkg.sv @@
// Shared types, encodings and decode helpers for the RV32 subset execute unit.
`default_nettype none

package rv32sx_pkg;

  localparam int XLEN      = 32;
  localparam int REG_COUNT = 32;
  localparam int REG_AW    = 5;

  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] OPC_REG    = 7'h33;
  localparam logic [6:0] F7_MULDIV  = 7'h01;

  localparam logic [2:0] F3_ADDI    = 3'd0;
  localparam logic [2:0] F3_SLT     = 3'd2;
  localparam logic [2:0] F3_SLTU    = 3'd3;

  localparam logic [XLEN-1:0] WORD_EBREAK = 32'h0010_0073;
  localparam logic [XLEN-1:0] UPPER_MASK  = 32'hFFFF_F000;
  localparam logic [XLEN-1:0] SP_RESET    = 32'h0025_A000;
  localparam logic [REG_AW-1:0] REG_ZERO  = 5'd0;
  localparam logic [REG_AW-1:0] REG_SP    = 5'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ILLEGAL = 2'd1;
  localparam logic [1:0] ST_ECALL   = 2'd2;
  localparam logic [1:0] ST_EBREAK  = 2'd3;

  // Command for the serial multiply/divide unit.
  typedef struct packed {
    logic is_div;  // divide when set, multiply otherwise
    logic upper;   // high product word or remainder
    logic sgn;     // operands are signed
  } md_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic       wr;
    logic       use_md;
    md_cmd_t    cmd;
  } dec_t;

  function automatic dec_t rv32sx_decode(input logic [XLEN-1:0] instr);
    dec_t       d;
    logic [2:0] f3;
    d  = '0;
    f3 = instr[14:12];
    d.status = ST_OK;
    unique case (instr[6:0])
      OPC_IMM: begin
        if (f3 == F3_ADDI) begin
          d.wr = 1'b1;
        end else begin
          d.status = ST_ILLEGAL;
        end
      end
      OPC_LUI, OPC_AUIPC: begin
        d.wr = 1'b1;
      end
      OPC_REG: begin
        if (f3 == F3_SLT || f3 == F3_SLTU) begin
          d.status = ST_ILLEGAL;
        end else if (instr[31:25] == F7_MULDIV) begin
          d.wr         = 1'b1;
          d.use_md     = 1'b1;
          d.cmd.is_div = f3[2];
          d.cmd.upper  = f3[2] ? f3[1] : f3[0];
          d.cmd.sgn    = f3[2] ? ~f3[0] : f3[0];
        end
      end
      OPC_SYSTEM: begin
        d.status = (instr == WORD_EBREAK) ? ST_EBREAK : ST_ECALL;
      end
      default: begin
        d.status = ST_ILLEGAL;
      end
    endcase
    return d;
  endfunction

  function automatic logic [XLEN-1:0] rv32sx_reset_value(input logic [REG_AW-1:0] idx);
    return (idx == REG_SP) ? SP_RESET : '0;
  endfunction

endpackage

`default_nettype wire

@@ sv/rv32sx_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rv32sx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/rv32sx_regs.sv @@
// Register file: RAM plus per-entry valid bits that supply reset values.
`default_nettype none

module rv32sx_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [rv32sx_pkg::REG_AW-1:0]    raddr,
  output logic [rv32sx_pkg::XLEN-1:0]      rdata,
  input  logic                             we,
  input  logic [rv32sx_pkg::REG_AW-1:0]    waddr,
  input  logic [rv32sx_pkg::XLEN-1:0]      wdata
);
  import rv32sx_pkg::*;

  logic [REG_COUNT-1:0] valid;
  logic                 valid_q;
  logic [REG_AW-1:0]    addr_q;
  logic [XLEN-1:0]      ram_q;

  rv32sx_ram #(
    .WIDTH(XLEN),
    .DEPTH(REG_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    addr_q  <= raddr;
    valid_q <= valid[raddr];
  end

  // An entry never written since reset reads its reset value; x0 always reads zero.
  always_comb begin
    if (addr_q == REG_ZERO) begin
      rdata = '0;
    end else if (valid_q) begin
      rdata = ram_q;
    end else begin
      rdata = rv32sx_reset_value(addr_q);
    end
  end

endmodule

`default_nettype wire

@@ sv/rv32sx_muldiv.sv @@
// Radix-2 serial multiplier and restoring divider sharing one adder.
`default_nettype none

module rv32sx_muldiv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  rv32sx_pkg::md_cmd_t         cmd,
  input  logic [rv32sx_pkg::XLEN-1:0] a,
  input  logic [rv32sx_pkg::XLEN-1:0] b,
  output logic                        done,
  output logic [rv32sx_pkg::XLEN-1:0] result
);
  import rv32sx_pkg::*;

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_RUN  = 3'b010,
    MD_FIX  = 3'b100
  } md_state_t;

  localparam int CW = $clog2(XLEN);
  localparam logic [CW-1:0] CNT_LAST = CW'(XLEN - 1);

  md_state_t       state;
  logic [CW-1:0]   cnt;
  logic [XLEN-1:0] hi;
  logic [XLEN-1:0] lo;
  logic [XLEN-1:0] opnd;
  md_cmd_t         cmd_q;
  logic            neg;

  logic [XLEN-1:0] mag_a;
  logic [XLEN-1:0] mag_b;
  logic            b_zero;
  logic            neg_start;
  logic [XLEN+1:0] base;
  logic [XLEN+1:0] addend;
  logic [XLEN+1:0] sum;
  logic            borrow;
  logic [XLEN-1:0] hi_next;
  logic [XLEN-1:0] lo_next;
  logic [XLEN-1:0] fix_x;
  logic [XLEN-1:0] fix_cin;
  logic [XLEN-1:0] fix_val;

  always_comb begin
    mag_a  = (cmd.sgn && a[XLEN-1]) ? (~a + 1'b1) : a;
    mag_b  = (cmd.sgn && b[XLEN-1]) ? (~b + 1'b1) : b;
    b_zero = (b == '0);
    // Sign of the final result; a zero divisor keeps the all-ones quotient.
    if (cmd.is_div && cmd.upper) begin
      neg_start = cmd.sgn & a[XLEN-1];
    end else if (cmd.is_div) begin
      neg_start = cmd.sgn & (a[XLEN-1] ^ b[XLEN-1]) & ~b_zero;
    end else begin
      neg_start = cmd.sgn & (a[XLEN-1] ^ b[XLEN-1]);
    end
  end

  // One step: add the multiplicand when the low bit is set, or try a subtract of the divisor.
  always_comb begin
    if (cmd_q.is_div) begin
      base   = {1'b0, hi, lo[XLEN-1]};
      addend = ~{2'b00, opnd};
    end else begin
      base   = {2'b00, hi};
      addend = lo[0] ? {2'b00, opnd} : '0;
    end
    sum    = base + addend + {{(XLEN+1){1'b0}}, cmd_q.is_div};
    borrow = sum[XLEN+1];
    if (cmd_q.is_div) begin
      hi_next = borrow ? {hi[XLEN-2:0], lo[XLEN-1]} : sum[XLEN-1:0];
      lo_next = {lo[XLEN-2:0], ~borrow};
    end else begin
      hi_next = sum[XLEN:1];
      lo_next = {sum[0], lo[XLEN-1:1]};
    end
  end

  // The high product word negates with a carry in only when the low word is zero.
  always_comb begin
    fix_x   = cmd_q.upper ? hi : lo;
    fix_cin = (cmd_q.is_div || lo == '0) ? XLEN'(1) : '0;
    fix_val = neg ? (~fix_x + fix_cin) : fix_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        MD_IDLE: begin
          if (start) begin
            hi    <= '0;
            lo    <= mag_a;
            opnd  <= mag_b;
            cmd_q <= cmd;
            neg   <= neg_start;
            cnt   <= '0;
            state <= MD_RUN;
          end
        end
        MD_RUN: begin
          hi  <= hi_next;
          lo  <= lo_next;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= MD_FIX;
          end
        end
        MD_FIX: begin
          result <= fix_val;
          done   <= 1'b1;
          state  <= MD_IDLE;
        end
        default: begin
          state <= MD_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/rv32_subset_execute_unit.sv @@
// Top level of the RV32 subset execute unit: sequencer, operand fetch and result register.
`default_nettype none

// Executes one instruction at a time against a 32-entry register file (x0 reads zero, x2 resets
// to 0x25A000). ADDI, LUI and AUIPC pass through the states IDLE, RD1, RD2, EXEC and DONE;
// MUL, MULH, DIV, DIVU, REM and REMU also wait in WAIT for the 32 one-bit steps of the
// shared shift-and-add / restoring-divide unit. The two source registers are read one after the
// other through the single read port of the register file RAM. Every instruction yields exactly
// one result; ECALL, EBREAK and illegal encodings are only reported in status. A result waiting
// in the output register does not block the next input transfer.
module rv32_subset_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [31:0] instruction,
  input  logic [31:0] instr_address,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic        write_enable,
  output logic [4:0]  dest_reg,
  output logic [31:0] dest_value
);
  import rv32sx_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD1  = 6'b000010,
    S_RD2  = 6'b000100,
    S_EXEC = 6'b001000,
    S_WAIT = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t          state;
  logic [XLEN-1:0] word;
  logic [XLEN-1:0] pc;
  logic [XLEN-1:0] op_a;
  logic [XLEN-1:0] op_b;
  logic [XLEN-1:0] result;

  dec_t              dec;
  logic [REG_AW-1:0] rd;
  logic [REG_AW-1:0] rf_raddr;
  logic [XLEN-1:0]   rf_rdata;
  logic              rf_we;
  logic              accept;
  logic              out_free;
  logic              md_start;
  logic              md_done;
  logic [XLEN-1:0]   md_result;
  logic [XLEN-1:0]   imm;
  logic [XLEN-1:0]   upper;
  logic [XLEN-1:0]   alu_val;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign dec       = rv32sx_decode(word);
  assign rd        = word[11:7];
  assign md_start  = (state == S_EXEC) && dec.use_md;
  assign rf_we     = (state == S_DONE) && out_free && dec.wr && (rd != REG_ZERO);
  assign rf_raddr  = (state == S_IDLE) ? instruction[19:15] : word[24:20];

  always_comb begin
    imm   = {{(XLEN-12){word[31]}}, word[31:20]};
    upper = word & UPPER_MASK;
    if (word[6:0] == OPC_IMM) begin
      alu_val = op_a + imm;
    end else if (word[6:0] == OPC_AUIPC) begin
      alu_val = pc + upper;
    end else begin
      alu_val = upper;
    end
  end

  rv32sx_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .raddr(rf_raddr),
    .rdata(rf_rdata),
    .we   (rf_we),
    .waddr(rd),
    .wdata(result)
  );

  rv32sx_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .cmd   (dec.cmd),
    .a     (op_a),
    .b     (op_b),
    .done  (md_done),
    .result(md_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            word  <= instruction;
            pc    <= instr_address;
            state <= S_RD1;
          end
        end
        S_RD1: begin
          op_a  <= rf_rdata;
          state <= S_RD2;
        end
        S_RD2: begin
          op_b  <= rf_rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          result <= alu_val;
          state  <= dec.use_md ? S_WAIT : S_DONE;
        end
        S_WAIT: begin
          if (md_done) begin
            result <= md_result;
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            // A discarded write, including one to x0, shows zeros in the destination fields.
            status       <= dec.status;
            write_enable <= dec.wr && (rd != REG_ZERO);
            dest_reg     <= (dec.wr && rd != REG_ZERO) ? rd : REG_ZERO;
            dest_value   <= (dec.wr && rd != REG_ZERO) ? result : '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_wr_has_dest: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && write_enable |-> dest_reg != REG_ZERO)
    else $error("write reported with destination x0");

  a_no_wr_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !write_enable |-> dest_reg == REG_ZERO && dest_value == '0)
    else $error("destination fields not cleared without a write");

  a_fault_no_wr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> !write_enable)
    else $error("register write reported together with a fault status");

  a_md_done_waiting: assert property (@(posedge clk) disable iff (rst)
    md_done |-> state == S_WAIT)
    else $error("multiply/divide result arrived outside the wait state");

  a_write_reported: assert property (@(posedge clk) disable iff (rst)
    rf_we |=> rsp_valid && write_enable)
    else $error("register file write not reported in the result");
`endif

endmodule

`default_nettype wire
